// File: sv/mlfq_pkg.sv
package mlfq_pkg;

    localparam int LEVELS_DEF      = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PID_WIDTH_DEF   = 8;

    // item modes
    localparam logic [1:0] MODE_ADMIT  = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    // run outcomes carried by a report item
    localparam logic [1:0] OUT_RUNNING  = 2'd0;
    localparam logic [1:0] OUT_FINISHED = 2'd1;
    localparam logic [1:0] OUT_BLOCKED  = 2'd2;

    // event codes on the result
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_FINISHED = 2'd1;
    localparam logic [1:0] EV_BLOCKED  = 2'd2;
    localparam logic [1:0] EV_DEMOTED  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

endpackage

// File: sv/mlfq_pick.sv
module mlfq_pick
    import mlfq_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1
)(
    input  logic [LEVELS-1:0] nonempty,
    output logic              found,
    output logic [LW-1:0]     sel
);

    // lowest non-empty level wins: scan from the bottom so level 0 overrides
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                found = 1'b1;
                sel   = LW'(i);
            end
        end
    end

endmodule

// File: sv/mlfq_scheduler.sv
// Channel   Handshake          Fields
// command   start / busy       mode, pid, level, outcome
// result    done (one cycle)   run_valid, run_pid, run_level, quantum, slot_used,
//                              event_res, dest_level, queue_full
//
// Admit, report, ignored items and ticks that dequeue nothing strobe the result in
// the cycle after acceptance. A tick that dequeues first passes through ST_FETCH, where
// the registered queue memory read is taken and done is raised; busy is high in ST_FETCH.
// Reset clears pointers, counts and the running process; the queue memory
// holds no reset value and needs no clearing pass. The receiver cannot stall.
module mlfq_scheduler
    import mlfq_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PID_WIDTH   = PID_WIDTH_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic [PID_WIDTH-1:0] pid,
    input  logic [1:0]           level,
    input  logic [1:0]           outcome,
    output logic                 done,
    output logic                 run_valid,
    output logic [PID_WIDTH-1:0] run_pid,
    output logic [1:0]           run_level,
    output logic [3:0]           quantum,
    output logic [3:0]           slot_used,
    output logic [1:0]           event_res,
    output logic [1:0]           dest_level,
    output logic                 queue_full
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = LEVELS;
    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int AW = $clog2(MEM_DEPTH);

    logic [PID_WIDTH-1:0] mem [MEM_DEPTH];
    logic [PID_WIDTH-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [PW-1:0]        head_reg  [LEVELS];
    logic [PW-1:0]        head_next [LEVELS];
    logic [PW-1:0]        tail_reg  [LEVELS];
    logic [PW-1:0]        tail_next [LEVELS];
    logic [CW-1:0]        count_reg [LEVELS];
    logic [CW-1:0]        count_next[LEVELS];
    logic                 rv_reg, rv_next;
    logic [PID_WIDTH-1:0] rpid_reg, rpid_next;
    logic [LW-1:0]        rlvl_reg, rlvl_next;
    logic [SW-1:0]        slots_reg, slots_next;
    logic                 done_reg, done_next;

    logic                 res_valid_reg;
    logic [PID_WIDTH-1:0] res_pid_reg;
    logic [1:0]           res_level_reg;
    logic [3:0]           res_quantum_reg;
    logic [3:0]           res_slot_reg;
    logic [1:0]           res_event_reg;
    logic [1:0]           res_dest_reg;
    logic                 res_full_reg;

    logic [LEVELS-1:0]    nonempty;
    logic                 pick_found;
    logic [LW-1:0]        pick_lvl;

    logic [3:0]           lvl_ext;
    logic [LW-1:0]        lvl_mod;
    logic                 push_req;
    logic [LW-1:0]        push_lvl;
    logic [PID_WIDTH-1:0] push_pid;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic                 rep_active, release_run;
    logic [SW-1:0]        slots_inc, quantum_full, shown_slots;
    logic [LW-1:0]        rl_dest;
    logic [1:0]           ev;
    logic [LW-1:0]        dest;
    logic                 full;

    logic                 show_valid;
    logic [PID_WIDTH-1:0] show_pid;
    logic [LW-1:0]        show_lvl;
    logic [SW-1:0]        show_slots;
    logic [7:0]           lvl8, q8, slot8, dest8;

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [PW-1:0] p);
        return AW'(AW'(l) * AW'(QUEUE_DEPTH)) + AW'(p);
    endfunction

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    mlfq_pick #(
        .LEVELS (LEVELS)
    ) u_pick (
        .nonempty (nonempty),
        .found    (pick_found),
        .sel      (pick_lvl)
    );

    assign busy = (state_reg != ST_IDLE);

    // fold an out-of-range admit level back into range
    assign lvl_ext = {2'b00, level};
    assign lvl_mod = (lvl_ext >= 4'(LEVELS)) ? LW'(lvl_ext - 4'(LEVELS)) : LW'(lvl_ext);

    assign slots_inc    = slots_reg + SW'(1);
    assign quantum_full = SW'(1) << rlvl_reg;
    assign rl_dest      = (rlvl_reg == LW'(LEVELS - 1)) ? rlvl_reg : rlvl_reg + LW'(1);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        rv_next     = rv_reg;
        rpid_next   = rpid_reg;
        rlvl_next   = rlvl_reg;
        slots_next  = slots_reg;
        state_next  = state_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        wr_addr     = '0;
        rd_addr     = '0;
        push_req    = 1'b0;
        push_lvl    = lvl_mod;
        push_pid    = pid;
        rep_active  = 1'b0;
        release_run = 1'b0;
        shown_slots = slots_reg;
        ev          = EV_NONE;
        dest        = '0;
        full        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_ADMIT:
                        begin
                            push_req = 1'b1;
                        end
                        MODE_TICK:
                        begin
                            if (!rv_reg && pick_found)
                            begin
                                mem_re              = 1'b1;
                                rd_addr             = addr_of(pick_lvl, head_reg[pick_lvl]);
                                head_next[pick_lvl] = next_pos(head_reg[pick_lvl]);
                                count_next[pick_lvl] = count_reg[pick_lvl] - CW'(1);
                                rv_next             = 1'b1;
                                rlvl_next           = pick_lvl;
                                slots_next          = '0;
                                state_next          = ST_FETCH;
                            end
                        end
                        MODE_REPORT:
                        begin
                            if (rv_reg)
                            begin
                                case (outcome)
                                    OUT_FINISHED:
                                    begin
                                        rep_active  = 1'b1;
                                        ev          = EV_FINISHED;
                                        release_run = 1'b1;
                                    end
                                    OUT_BLOCKED:
                                    begin
                                        rep_active  = 1'b1;
                                        ev          = EV_BLOCKED;
                                        release_run = 1'b1;
                                    end
                                    OUT_RUNNING:
                                    begin
                                        rep_active  = 1'b1;
                                        shown_slots = slots_inc;
                                        slots_next  = slots_inc;
                                        // quantum used up: demote; last level stays
                                        if (slots_inc >= quantum_full)
                                        begin
                                            ev          = EV_DEMOTED;
                                            dest        = rl_dest;
                                            push_req    = 1'b1;
                                            push_lvl    = rl_dest;
                                            push_pid    = rpid_reg;
                                            release_run = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (push_req)
                    begin
                        if (count_reg[push_lvl] == CW'(QUEUE_DEPTH))
                        begin
                            full = 1'b1;
                        end
                        else
                        begin
                            mem_we               = 1'b1;
                            wr_addr              = addr_of(push_lvl, tail_reg[push_lvl]);
                            tail_next[push_lvl]  = next_pos(tail_reg[push_lvl]);
                            count_next[push_lvl] = count_reg[push_lvl] + CW'(1);
                        end
                    end

                    if (release_run)
                    begin
                        rv_next    = 1'b0;
                        rpid_next  = '0;
                        rlvl_next  = '0;
                        slots_next = '0;
                    end

                    done_next = (state_next == ST_IDLE);
                end
            end
            ST_FETCH:
            begin
                rpid_next  = rd_data_reg;
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a report shows the process it concerns, even when that report releases it
    always_comb
    begin
        if (rep_active)
        begin
            show_valid = 1'b1;
            show_pid   = rpid_reg;
            show_lvl   = rlvl_reg;
            show_slots = shown_slots;
        end
        else if (rv_next)
        begin
            show_valid = 1'b1;
            show_pid   = rpid_next;
            show_lvl   = rlvl_next;
            show_slots = slots_next;
        end
        else
        begin
            show_valid = 1'b0;
            show_pid   = '0;
            show_lvl   = '0;
            show_slots = '0;
        end
        lvl8  = 8'(show_lvl);
        q8    = show_valid ? (8'(1) << show_lvl) : 8'(0);
        slot8 = 8'(show_slots);
        dest8 = 8'(dest);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= push_pid;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            rpid_reg  <= '0;
            rlvl_reg  <= '0;
            slots_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            rv_reg    <= rv_next;
            rpid_reg  <= rpid_next;
            rlvl_reg  <= rlvl_next;
            slots_reg <= slots_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // hold the result fields; only the strobe needs a reset
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            res_valid_reg   <= show_valid;
            res_pid_reg     <= show_pid;
            res_level_reg   <= lvl8[1:0];
            res_quantum_reg <= q8[3:0];
            res_slot_reg    <= slot8[3:0];
            res_event_reg   <= ev;
            res_dest_reg    <= dest8[1:0];
            res_full_reg    <= full;
        end
    end

    assign done       = done_reg;
    assign run_valid  = res_valid_reg;
    assign run_pid    = res_pid_reg;
    assign run_level  = res_level_reg;
    assign quantum    = res_quantum_reg;
    assign slot_used  = res_slot_reg;
    assign event_res  = res_event_reg;
    assign dest_level = res_dest_reg;
    assign queue_full = res_full_reg;

endmodule
